[src/pga_pkg.sv]
// Shared types, constants and elaboration-time functions for the pixel
// gamma and alpha conversion block. Depends on nothing else.
package pga_pkg;

  localparam int FIELD_W   = 16;
  localparam int LOG_FRAC  = 20;
  localparam int GAMMA_LAT = 2 * LOG_FRAC + 4;

  localparam logic [15:0] GAMMA_ONE = 16'd4096;
  localparam logic [15:0] GAMMA_TOL = 16'd40;

  localparam int LAYOUT_ALPHA_BIT = 0;
  localparam int LAYOUT_COLOR_BIT = 1;

  localparam logic [1:0] MODE_PRE       = 2'b01;
  localparam int         MODE_UNPRE_BIT = 1;

  localparam logic [15:0] GAMMA_RESET  = 16'd4096;
  localparam logic [1:0]  MODE_RESET   = 2'b00;
  localparam logic [1:0]  LAYOUT_RESET = 2'b11;

  typedef enum logic [1:0] {
    REG_GAMMA      = 2'd0,
    REG_ALPHA_MODE = 2'd1,
    REG_LAYOUT     = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [FIELD_W-1:0] red_or_gray;
    logic [FIELD_W-1:0] green_in;
    logic [FIELD_W-1:0] blue_in;
    logic [FIELD_W-1:0] alpha_in;
  } in_pix_t;

  typedef struct packed {
    logic [FIELD_W-1:0] red_or_gray_out;
    logic [FIELD_W-1:0] green_out;
    logic [FIELD_W-1:0] blue_out;
    logic [FIELD_W-1:0] alpha_out;
  } out_pix_t;

  typedef struct packed {
    logic pre;
    logic unpre;
  } alpha_ctl_t;

  function automatic longint unsigned isqrt64(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    longint unsigned rem;
    r   = 0;
    rem = v;
    b   = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= r + b) begin
        rem = rem - (r + b);
        r   = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] exp_const(int k);
    longint unsigned c;
    c = isqrt64(64'd1 << 63);
    for (int i = 1; i < k; i++) c = isqrt64(c << 32);
    return c[31:0];
  endfunction

  function automatic longint unsigned log2_fix(longint unsigned v);
    int unsigned     p;
    longint unsigned m;
    longint unsigned frac;
    p    = 0;
    frac = 0;
    while (p < 40 && (v >> (p + 1)) != 0) p++;
    m = (p <= 31) ? (v << (31 - p)) : (v >> (p - 31));
    for (int i = 0; i < LOG_FRAC; i++) begin
      m    = (m * m) >> 31;
      frac = frac << 1;
      if (m >= (64'd1 << 32)) begin
        frac = frac | 64'd1;
        m    = m >> 1;
      end
    end
    return (64'(p) << LOG_FRAC) | frac;
  endfunction

endpackage

[src/pga_gamma_lane.sv]
// One colour component raised to the gamma exponent through a fixed-point
// logarithm, a multiply and an exponential. Uses pga_pkg.
module pga_gamma_lane #(
  parameter int CB = 16
) (
  input  logic          clk,
  input  logic          adv,
  input  logic          bypass_i,
  input  logic [15:0]   gamma_i,
  input  logic [CB-1:0] x_i,
  output logic [CB-1:0] res_o
);

  localparam int LF   = pga_pkg::LOG_FRAC;
  localparam int P_W  = $clog2(CB);
  localparam int LX_W = P_W + LF;
  localparam int PR_W = LX_W + 17;
  localparam int E_W  = LX_W + 5;
  localparam int N_W  = E_W - LF;
  localparam int MQ_W = CB + 33;
  localparam logic [CB-1:0] MAXV = '1;
  localparam logic [LX_W-1:0] LM =
    LX_W'(pga_pkg::log2_fix((64'd1 << CB) - 64'd1));

  logic [31:0]   lm_r   [LF+1];
  logic [LF-1:0] lf_r   [LF+1];
  logic [P_W-1:0] lp_r  [LF+1];
  logic          lsp_r  [LF+1];
  logic [CB-1:0] lspv_r [LF+1];

  logic [32:0]   q_r    [LF+1];
  logic [LF-1:0] f_r    [LF+1];
  logic [N_W-1:0] n_r   [LF+1];
  logic          esp_r  [LF+1];
  logic [CB-1:0] espv_r [LF+1];

  logic [MQ_W-1:0] mq_r;
  logic [N_W-1:0]  mn_r;
  logic            msp_r;
  logic [CB-1:0]   mspv_r;
  logic [CB-1:0]   res_r;

  logic [P_W-1:0]  p_nxt;
  logic [31:0]     m_nxt;
  logic            sp_nxt;
  logic [CB-1:0]   spv_nxt;
  logic [LX_W-1:0] lx;
  logic [LX_W-1:0] dl;
  logic [PR_W-1:0] prod;
  logic [E_W-1:0]  e_val;
  logic [63:0]     sum;
  logic [5:0]      sh;
  logic [CB-1:0]   res_nxt;

  always_comb begin
    p_nxt = '0;
    for (int b = 0; b < CB; b++) begin
      if (x_i[b]) p_nxt = P_W'(b);
    end
    m_nxt = 32'(x_i) << (6'd31 - 6'(p_nxt));
    sp_nxt = bypass_i || (x_i == '0) || (x_i == MAXV);
    if (bypass_i) begin
      spv_nxt = x_i;
    end else if (x_i == '0) begin
      spv_nxt = (gamma_i == '0) ? MAXV : '0;
    end else begin
      spv_nxt = MAXV;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lm_r[0]   <= m_nxt;
      lf_r[0]   <= '0;
      lp_r[0]   <= p_nxt;
      lsp_r[0]  <= sp_nxt;
      lspv_r[0] <= spv_nxt;
    end
  end

  for (genvar i = 0; i < LF; i++) begin : g_log
    logic [63:0] sq;
    logic [32:0] t;
    assign sq = 64'(lm_r[i]) * 64'(lm_r[i]);
    assign t  = sq[63:31];
    always_ff @(posedge clk) begin
      if (adv) begin
        lm_r[i+1]   <= t[32] ? t[32:1] : t[31:0];
        lf_r[i+1]   <= {lf_r[i][LF-2:0], t[32]};
        lp_r[i+1]   <= lp_r[i];
        lsp_r[i+1]  <= lsp_r[i];
        lspv_r[i+1] <= lspv_r[i];
      end
    end
  end

  always_comb begin
    lx    = {lp_r[LF], lf_r[LF]};
    dl    = (LM > lx) ? (LM - lx) : '0;
    prod  = PR_W'(dl) * PR_W'(gamma_i) + PR_W'(2048);
    e_val = prod[PR_W-1:12];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q_r[0]    <= 33'h1_0000_0000;
      f_r[0]    <= e_val[LF-1:0];
      n_r[0]    <= e_val[E_W-1:LF];
      esp_r[0]  <= lsp_r[LF];
      espv_r[0] <= lspv_r[LF];
    end
  end

  for (genvar i = 0; i < LF; i++) begin : g_exp
    localparam logic [31:0] CK = pga_pkg::exp_const(i + 1);
    logic [64:0] qc;
    assign qc = 65'(q_r[i]) * 65'(CK);
    always_ff @(posedge clk) begin
      if (adv) begin
        q_r[i+1]    <= f_r[i][LF-1-i] ? qc[64:32] : q_r[i];
        f_r[i+1]    <= f_r[i];
        n_r[i+1]    <= n_r[i];
        esp_r[i+1]  <= esp_r[i];
        espv_r[i+1] <= espv_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mq_r   <= MQ_W'(MAXV) * MQ_W'(q_r[LF]);
      mn_r   <= n_r[LF];
      msp_r  <= esp_r[LF];
      mspv_r <= espv_r[LF];
    end
  end

  always_comb begin
    sh      = 6'd32 + 6'(mn_r[4:0]);
    sum     = 64'(mq_r) + (64'd1 << (6'd31 + 6'(mn_r[4:0])));
    res_nxt = CB'(sum >> sh);
    if (msp_r) begin
      res_nxt = mspv_r;
    end else if (mn_r >= N_W'(31)) begin
      res_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) res_r <= res_nxt;
  end

  assign res_o = res_r;

endmodule

[src/pga_alpha_lane.sv]
// Premultiply or unpremultiply of one colour component by alpha, with a
// bit-per-stage restoring divider. Uses pga_pkg.
module pga_alpha_lane #(
  parameter int CB = 16
) (
  input  logic                clk,
  input  logic                adv,
  input  pga_pkg::alpha_ctl_t ctl_i,
  input  logic [CB-1:0]       c_i,
  input  logic [CB-1:0]       a_i,
  output logic [CB-1:0]       res_o
);

  localparam int W2 = 2 * CB;
  localparam logic [CB-1:0] MAXV = '1;
  localparam logic [CB-1:0] HALF = MAXV >> 1;

  logic [W2-1:0] num_r;
  logic [CB-1:0] c0_r;
  logic [CB-1:0] a0_r;

  logic [W2-1:0] rem_r  [CB+1];
  logic [CB-1:0] q_r    [CB+1];
  logic [CB-1:0] pres_r [CB+1];
  logic          sat_r  [CB+1];
  logic [CB-1:0] c_r    [CB+1];
  logic [CB-1:0] a_r    [CB+1];

  logic [CB-1:0] res_r;
  logic [W2-1:0] num_nxt;
  logic [CB-1:0] q0;
  logic [CB:0]   rr;
  logic [CB-1:0] pres_nxt;
  logic [CB-1:0] res_nxt;

  always_comb begin
    if (ctl_i.pre) begin
      num_nxt = W2'(c_i) * W2'(a_i) + W2'(HALF);
    end else begin
      num_nxt = W2'(c_i) * W2'(MAXV) + W2'(a_i >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num_r <= num_nxt;
      c0_r  <= c_i;
      a0_r  <= a_i;
    end
  end

  always_comb begin
    q0       = num_r[W2-1:CB];
    rr       = {1'b0, num_r[CB-1:0]} + {1'b0, q0};
    pres_nxt = (rr >= {1'b0, MAXV}) ? (q0 + 1'b1) : q0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0]  <= num_r;
      q_r[0]    <= '0;
      pres_r[0] <= pres_nxt;
      sat_r[0]  <= num_r >= {a0_r, {CB{1'b0}}};
      c_r[0]    <= c0_r;
      a_r[0]    <= a0_r;
    end
  end

  for (genvar i = 0; i < CB; i++) begin : g_div
    localparam int S = CB - 1 - i;
    logic [W2-1:0] d;
    logic          ge;
    assign d  = W2'(a_r[i]) << S;
    assign ge = rem_r[i] >= d;
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[i+1]  <= ge ? (rem_r[i] - d) : rem_r[i];
        q_r[i+1]    <= {q_r[i][CB-2:0], ge};
        pres_r[i+1] <= pres_r[i];
        sat_r[i+1]  <= sat_r[i];
        c_r[i+1]    <= c_r[i];
        a_r[i+1]    <= a_r[i];
      end
    end
  end

  always_comb begin
    res_nxt = c_r[CB];
    if (ctl_i.pre) begin
      res_nxt = pres_r[CB];
    end else if (ctl_i.unpre && (a_r[CB] != '0)) begin
      res_nxt = sat_r[CB] ? MAXV : q_r[CB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) res_r <= res_nxt;
  end

  assign res_o = res_r;

endmodule

[src/pga_out_buf.sv]
// Output register with a one-entry skid stage for the result channel.
// Uses pga_pkg for the result type.
module pga_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pv_i,
  input  pga_pkg::out_pix_t pd_i,
  output logic              full_o,
  output logic              out_valid,
  input  logic              out_stall,
  output pga_pkg::out_pix_t out_data
);

  logic              ov_r;
  logic              sv_r;
  pga_pkg::out_pix_t od_r;
  pga_pkg::out_pix_t sd_r;
  logic              take;

  assign take = ov_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      sv_r <= 1'b0;
    end else if (!sv_r) begin
      if (!ov_r || take) begin
        ov_r <= pv_i;
        od_r <= pd_i;
      end else if (pv_i) begin
        sv_r <= 1'b1;
        sd_r <= pd_i;
      end
    end else if (take) begin
      ov_r <= 1'b1;
      od_r <= sd_r;
      sv_r <= 1'b0;
    end
  end

  assign full_o    = sv_r;
  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule

[src/pixel_gamma_alpha_convert.sv]
// Top level of the pixel gamma and alpha conversion block: configuration
// registers, lane pipelines and the valid line. Uses pga_pkg and all pga_ modules.
//
// Pixels arrive on the in_ channel (in_valid, in_stall, in_data) and leave
// on the out_ channel; a request is taken when valid is high and stall low.
// Each colour component runs through its own gamma lane (priority encode,
// twenty squaring steps of the logarithm, the exponent multiply, twenty
// conditional multiplies of the exponential, a final scale) and then an
// alpha lane (multiply, constant division, one divider step per bit).
// One pixel is accepted every cycle while in_stall is low. The pipeline holds
// 2*20+4 gamma stages, COMPONENT_BITS+3 alpha stages and the output register.
// Reset clears all valid bits and loads the register reset values. When the
// receiver stalls, the result waits in the output register, one further
// result goes to a skid stage, and only then is in_stall raised; the whole
// pipeline then holds until the output is taken. Registers: gamma exponent at
// 0x0, alpha mode at 0x4, channel layout at 0x8; configuration is written by
// the user only while no pixels are in flight; the block does not enforce it.
module pixel_gamma_alpha_convert #(
  parameter int COMPONENT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pga_pkg::in_pix_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output pga_pkg::out_pix_t out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [3:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam int CB  = COMPONENT_BITS;
  localparam int GL  = pga_pkg::GAMMA_LAT;
  localparam int LAT = GL + CB + 3;

  logic [15:0] gamma_r;
  logic [1:0]  mode_r;
  logic [1:0]  layout_r;

  logic          vld_r [LAT];
  logic [CB-1:0] ad_r  [LAT];

  logic                adv;
  logic                full;
  logic                bypass;
  logic                alpha_on;
  logic                color;
  pga_pkg::alpha_ctl_t actl;
  logic [CB-1:0]       xin   [3];
  logic [CB-1:0]       gres  [3];
  logic [CB-1:0]       ares  [3];
  pga_pkg::out_pix_t   pd;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gamma_r  <= pga_pkg::GAMMA_RESET;
      mode_r   <= pga_pkg::MODE_RESET;
      layout_r <= pga_pkg::LAYOUT_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (pga_pkg::reg_idx_t'(cfg_paddr[3:2]))
        pga_pkg::REG_GAMMA:      gamma_r  <= cfg_pwdata[15:0];
        pga_pkg::REG_ALPHA_MODE: mode_r   <= cfg_pwdata[1:0];
        pga_pkg::REG_LAYOUT:     layout_r <= cfg_pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (pga_pkg::reg_idx_t'(cfg_paddr[3:2]))
      pga_pkg::REG_GAMMA:      cfg_prdata = 32'(gamma_r);
      pga_pkg::REG_ALPHA_MODE: cfg_prdata = 32'(mode_r);
      pga_pkg::REG_LAYOUT:     cfg_prdata = 32'(layout_r);
      default:                 cfg_prdata = '0;
    endcase
  end

  assign alpha_on   = layout_r[pga_pkg::LAYOUT_ALPHA_BIT];
  assign color      = layout_r[pga_pkg::LAYOUT_COLOR_BIT];
  assign bypass     = !((17'(gamma_r) + 17'(pga_pkg::GAMMA_TOL) < 17'(pga_pkg::GAMMA_ONE))
                        || (17'(gamma_r) > 17'(pga_pkg::GAMMA_ONE) + 17'(pga_pkg::GAMMA_TOL)));
  assign actl.pre   = alpha_on && (mode_r == pga_pkg::MODE_PRE);
  assign actl.unpre = alpha_on && mode_r[pga_pkg::MODE_UNPRE_BIT];

  assign adv      = !full;
  assign in_stall = full;

  assign xin[0] = CB'(in_data.red_or_gray);
  assign xin[1] = CB'(in_data.green_in);
  assign xin[2] = CB'(in_data.blue_in);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) vld_r[i] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < LAT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ad_r[0] <= CB'(in_data.alpha_in);
      for (int i = 1; i < LAT; i++) ad_r[i] <= ad_r[i-1];
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    pga_gamma_lane #(.CB(CB)) u_gamma (
      .clk      (clk),
      .adv      (adv),
      .bypass_i (bypass),
      .gamma_i  (gamma_r),
      .x_i      (xin[l]),
      .res_o    (gres[l])
    );
    pga_alpha_lane #(.CB(CB)) u_alpha (
      .clk   (clk),
      .adv   (adv),
      .ctl_i (actl),
      .c_i   (gres[l]),
      .a_i   (ad_r[GL-1]),
      .res_o (ares[l])
    );
  end

  always_comb begin
    pd.red_or_gray_out = pga_pkg::FIELD_W'(ares[0]);
    pd.green_out       = color ? pga_pkg::FIELD_W'(ares[1]) : '0;
    pd.blue_out        = color ? pga_pkg::FIELD_W'(ares[2]) : '0;
    pd.alpha_out       = alpha_on ? pga_pkg::FIELD_W'(ad_r[LAT-1]) : '0;
  end

  pga_out_buf u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .pv_i      (vld_r[LAT-1]),
    .pd_i      (pd),
    .full_o    (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  a_stall_has_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid) else $error("input stalled with no result waiting");
  a_gray_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !color |-> (out_data.green_out == '0) && (out_data.blue_out == '0))
    else $error("gray layout produced colour components");
  a_no_alpha_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !alpha_on |-> out_data.alpha_out == '0)
    else $error("layout without alpha produced alpha");
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall) else $error("pipeline not empty after reset");
`endif

endmodule
